/* hw/rtl/ibt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ibt_pkg: shared types and constants of the interval booking table
// Word layouts of the request and result channels and the status codes.
// ----------------------------------------------------------------------------
package ibt_pkg;

  // Width of one time value as carried on the request channel.
  localparam int unsigned TIME_W = 32;

  // Width of the entries_used field of a result word.
  localparam int unsigned USED_W = 7;

  // Outcome of one booking request.
  typedef enum logic [1:0] {
    ST_BOOKED   = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FULL     = 2'd2,
    ST_INVALID  = 2'd3
  } ibt_status_t;

  // Request word: half-open interval [start_time, end_time).
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } ibt_req_t;

  // Result word: outcome and table fill after the request.
  typedef struct packed {
    ibt_status_t       status;
    logic [USED_W-1:0] entries_used;
  } ibt_rsp_t;

endpackage : ibt_pkg
`default_nettype wire

/* hw/rtl/interval_booking_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// interval_booking_table: table of non-overlapping half-open intervals
// Books a requested interval unless it overlaps a stored one, the table is
// full or the interval is empty; every request returns one result word.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on in_valid/in_ready, result words leave on
//   out_valid/out_ready. Each request yields exactly one result word.
//   A request is taken only while no other request is being worked on.
//   The stored intervals live in one synchronous memory that is scanned
//   one entry per cycle, from the first stored interval up to the fill
//   count, before the result is loaded. An empty or reversed interval, or
//   an empty table, skips the scan and goes straight to loading its result.
//   The result sits in an output register; a new request is accepted while
//   that result waits, and the block holds its next result back until the
//   register is free. A stalled receiver therefore stalls at most one
//   request in flight.
//   Reset empties the table by clearing the fill count; the memory itself
//   needs no clearing, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module interval_booking_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  ibt_pkg::ibt_req_t in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output ibt_pkg::ibt_rsp_t out_data
);
  import ibt_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } ibt_state_t;

  ibt_state_t        state_r, state_nxt;
  ibt_req_t          req_r, req_nxt;
  logic              conflict_r, conflict_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              last_iss_r, last_iss_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  ibt_rsp_t          out_data_r, out_data_nxt;
  ibt_req_t          rd_data_r;

  logic              in_fire;
  logic              out_free;
  logic              rd_en;
  logic              wr_en;
  logic              overlap;
  logic              req_invalid;
  logic              tbl_full;
  ibt_status_t       status;

  // Interval memory, one {start, end} word per stored interval.
  ibt_req_t mem [0:CAPACITY-1];

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Stored interval returned by the memory overlaps the held request.
  assign overlap = (rd_data_r.start_time < req_r.end_time) &&
                   (req_r.start_time < rd_data_r.end_time);

  // Outcome of the held request, in order of precedence.
  assign req_invalid = !(req_r.start_time < req_r.end_time);
  assign tbl_full    = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    priority if (req_invalid) begin
      status = ST_INVALID;
    end else if (conflict_r) begin
      status = ST_CONFLICT;
    end else if (tbl_full) begin
      status = ST_FULL;
    end else begin
      status = ST_BOOKED;
    end
  end

  // Sequencer: accept, scan the stored entries, then resolve and report.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    conflict_nxt  = conflict_r;
    scan_idx_nxt  = scan_idx_r;
    last_iss_nxt  = last_iss_r;
    count_nxt     = count_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    rd_en         = 1'b0;
    wr_en         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt      = in_data;
          conflict_nxt = 1'b0;
          scan_idx_nxt = '0;
          last_iss_nxt = 1'b0;
          if (!(in_data.start_time < in_data.end_time) || (count_r == '0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Issue one read a cycle until the last stored entry is requested.
        if (!last_iss_r) begin
          rd_en        = 1'b1;
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          if ((scan_idx_r + CNT_W'(1)) == count_r) begin
            last_iss_nxt = 1'b1;
          end
        end
        if (rd_vld_r && overlap) begin
          conflict_nxt = 1'b1;
        end
        // The last read has been compared once no read is outstanding.
        if (last_iss_r && !rd_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt.status = status;
          if (status == ST_BOOKED) begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            out_data_nxt.entries_used = USED_W'(count_r + CNT_W'(1));
          end else begin
            out_data_nxt.entries_used = USED_W'(count_r);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign rd_vld_nxt = rd_en;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      conflict_r  <= 1'b0;
      scan_idx_r  <= '0;
      last_iss_r  <= 1'b0;
      rd_vld_r    <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      conflict_r  <= conflict_nxt;
      scan_idx_r  <= scan_idx_nxt;
      last_iss_r  <= last_iss_nxt;
      rd_vld_r    <= rd_vld_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  // Memory ports. Writes happen only once any scan has finished, so a read
  // never meets a write to the same entry and no forwarding is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[IDX_W-1:0]] <= req_r;
    end
    if (rd_en) begin
      rd_data_r <= mem[scan_idx_r[IDX_W-1:0]];
    end
  end

endmodule : interval_booking_table
`default_nettype wire

/* hw/rtl/ibt_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ibt_checker: port-level checks of the interval booking table
// Watches both channels and checks result holds and counts against requests.
// ----------------------------------------------------------------------------
module ibt_checker (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_ready,
  input wire               out_valid,
  input wire               out_ready,
  input ibt_pkg::ibt_rsp_t out_data
);
  import ibt_pkg::*;

  logic [1:0] pend_r;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Requests accepted whose result word has not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_fire) - 2'(out_fire);
    end
  end

  // Reset leaves no result word on the output.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed");

  // Every delivered word answers an accepted request.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |-> (pend_r != 2'd0))
    else $error("result word without a request");

  // At most one request is worked on while one result waits.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many requests in flight");

endmodule : ibt_checker

bind interval_booking_table ibt_checker u_ibt_checker (.*);
`default_nettype wire

/* tb/sv/tb_interval_booking_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_interval_booking_table: self-checking bench for the interval booking table
// Sends booking request words and compares every result word, field by
// field, with a predictor that keeps its own copy of the interval table.
// A short directed run covers the edges, then a random run mixes overlapping,
// touching, fresh, invalid and wide requests under varying handshake stalls.
// ----------------------------------------------------------------------------
module tb_interval_booking_table;
  import ibt_pkg::*;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned RANDOM_ITEMS = 1830;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam longint unsigned TIME_MAX = 64'hFFFF_FFFF;

  // Predicts the result of each accepted request and checks result words in order.
  class booking_scoreboard;
    logic [TIME_W-1:0] starts [CAPACITY];
    logic [TIME_W-1:0] ends [CAPACITY];
    int unsigned fill;
    ibt_rsp_t expected_q[$];
    int unsigned mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    // Work out the outcome of one accepted request and update the table copy.
    function void note_request(ibt_req_t req);
      ibt_rsp_t rsp;
      bit clash;
      clash = 1'b0;
      if (!(req.start_time < req.end_time)) begin
        rsp.status = ST_INVALID;
      end else begin
        for (int unsigned i = 0; i < fill; i++) begin
          if (starts[i] < req.end_time && req.start_time < ends[i]) clash = 1'b1;
        end
        // Overlap wins over a full table.
        if (clash) begin
          rsp.status = ST_CONFLICT;
        end else if (fill >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          starts[fill] = req.start_time;
          ends[fill] = req.end_time;
          fill++;
          rsp.status = ST_BOOKED;
        end
      end
      rsp.entries_used = USED_W'(fill);
      expected_q.push_back(rsp);
    endfunction

    // Compare one result word with the oldest waiting expectation.
    function void check_result(ibt_rsp_t got);
      ibt_rsp_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("interval table: unexpected result word, status %0d used %0d",
                   got.status, got.entries_used);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.entries_used !== want.entries_used) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("interval table: mismatch, expected status %0d used %0d, got status %0d used %0d",
                   want.status, want.entries_used, got.status, got.entries_used);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  ibt_req_t in_data;
  logic out_valid;
  logic out_ready;
  ibt_rsp_t out_data;

  booking_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count = 0;

  interval_booking_table #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The receiver stalls at random with the current idle rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Check result words first, then note the request word taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_request(in_data);
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("interval table: timed out with %0d results outstanding", sb.pending());
      $display("tb_interval_booking_table: FAIL");
      $finish;
    end
  end

  // Offer one request word after a random gap and hold it until it is taken.
  task automatic send_request(input ibt_req_t req);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_interval(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e);
    ibt_req_t req;
    req.start_time = s;
    req.end_time = e;
    send_request(req);
  endtask

  // Hold off the sender until every result word has come back.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Build a random request, often aimed at intervals already in the table.
  function automatic ibt_req_t make_request();
    ibt_req_t req;
    int unsigned pick;
    int unsigned k;
    longint unsigned a, b, p, lim, s, e, x, y;
    pick = $urandom_range(0, 99);
    lim = (64'd1 << $urandom_range(0, 20)) - 1;
    k = $urandom_range(0, sb.fill - 1);
    a = sb.starts[k];
    b = sb.ends[k];
    if (pick < 15) begin
      // Empty or reversed interval.
      x = $urandom;
      y = ($urandom_range(0, 3) == 0) ? x : $urandom;
      s = (x > y) ? x : y;
      e = (x > y) ? y : x;
    end else if (pick < 45) begin
      // Straddle a point inside a stored interval.
      p = a + $urandom_range(0, 32'(b - a - 1));
      s = p - $urandom_range(0, 32'((p < lim) ? p : lim));
      e = p + 1 + $urandom_range(0, 32'((TIME_MAX - p - 1 < lim) ? TIME_MAX - p - 1 : lim));
    end else if (pick < 62) begin
      // Touch a stored interval at its start or its end.
      if ((a != 0 && $urandom_range(0, 1) == 1) || b == TIME_MAX) begin
        e = a;
        s = (a == 0) ? 0 : a - 1 - $urandom_range(0, 32'((a - 1 < lim) ? a - 1 : lim));
      end else begin
        s = b;
        e = b + 1 + $urandom_range(0, 32'((TIME_MAX - b - 1 < lim) ? TIME_MAX - b - 1 : lim));
      end
    end else if (pick < 74) begin
      // Short interval anywhere, usually free.
      s = $urandom;
      e = s + 1 + $urandom_range(0, 32'(lim));
      if (e > TIME_MAX) begin
        e = TIME_MAX;
        if (s >= e) s = e - 1;
      end
    end else if (pick < 88) begin
      s = $urandom;
      e = $urandom;
    end else begin
      // Near the ends of the time range.
      case ($urandom_range(0, 2))
        0: begin
          s = $urandom_range(0, 3);
          e = TIME_MAX - $urandom_range(0, 3);
        end
        1: begin
          s = TIME_MAX - $urandom_range(0, 4);
          e = TIME_MAX;
        end
        default: begin
          s = 0;
          e = $urandom_range(0, 4);
        end
      endcase
    end
    req.start_time = s[TIME_W-1:0];
    req.end_time = e[TIME_W-1:0];
    return req;
  endfunction

  // Reset, directed requests, then three random phases with different stalls.
  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 76;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty and reversed intervals on an empty table.
    send_interval(32'h0000_0000, 32'h0000_0000);
    send_interval(32'hFFFF_FFFF, 32'h0000_0000);
    send_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_interval(32'd5, 32'd4);
    // Bookings at both ends of the time range and touching neighbors.
    send_interval(32'd0, 32'd16);
    send_interval(32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_interval(32'd16, 32'd32);
    send_interval(32'd0, 32'd1);
    send_interval(32'd15, 32'd17);
    send_interval(32'd31, 32'd40);
    send_interval(32'd0, 32'hFFFF_FFFF);
    send_interval(32'hFFFF_FFEF, 32'hFFFF_FFF0);
    send_interval(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    // Fill a gap exactly from both sides.
    send_interval(32'd40, 32'd48);
    send_interval(32'd32, 32'd40);
    send_interval(32'd48, 32'd48);
    // Partial, inner and enclosing overlaps.
    send_interval(32'd100, 32'd200);
    send_interval(32'd50, 32'd150);
    send_interval(32'd150, 32'd250);
    send_interval(32'd120, 32'd130);
    send_interval(32'd90, 32'd210);
    wait_for_drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int unsigned n = 0; n < RANDOM_ITEMS / 3; n++) send_request(make_request());
      wait_for_drain();
    end

    // Let any stray result word show up before the verdict.
    repeat (CAPACITY + 8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("tb_interval_booking_table: PASS");
    end else begin
      $display("tb_interval_booking_table: FAIL");
    end
    $finish;
  end

endmodule
